// ----- rtl/core/mta_pkg.sv -----
// Shared types, constants and helper functions for the mesh tangent accumulator.
// Depends on nothing; the front end, divider, back end and top level refer to it by scoped names.
`default_nettype none

package mta_pkg;

    // Field widths of the external items.
    localparam int IDX_W     = 10;
    localparam int CMD_IDX_W = 16;
    localparam int POS_W     = 32;
    localparam int TEX_W     = 24;
    localparam int ACC_W     = 48;
    localparam int FRAC_W    = 16;

    // Datapath widths: edge deltas, UV deltas, products, numerators, determinant.
    localparam int PD_W   = POS_W + 1;
    localparam int TD_W   = TEX_W + 1;
    localparam int PROD_W = PD_W + TD_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int DET_W  = 2 * TD_W + 1;

    // Compare and subtract steps that fold a 10-bit index into the smallest table.
    localparam int REDUCE_STEPS = 7;

    localparam logic [31:0] THRESHOLD_RESET = 32'd42949673;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_TRIANGLE = 2'd1,
        OP_READ     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]              operation;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TEX_W-1:0] tex_u;
        logic signed [TEX_W-1:0] tex_v;
    } item_t;

    typedef struct packed {
        logic                    result_kind;
        logic                    degenerate;
        logic signed [ACC_W-1:0] tangent_x;
        logic signed [ACC_W-1:0] tangent_y;
        logic signed [ACC_W-1:0] tangent_z;
        logic signed [ACC_W-1:0] bitangent_x;
        logic signed [ACC_W-1:0] bitangent_y;
        logic signed [ACC_W-1:0] bitangent_z;
    } result_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TEX_W-1:0] tex_u;
        logic signed [TEX_W-1:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] tx;
        logic signed [ACC_W-1:0] ty;
        logic signed [ACC_W-1:0] tz;
        logic signed [ACC_W-1:0] bx;
        logic signed [ACC_W-1:0] by;
        logic signed [ACC_W-1:0] bz;
    } sums_t;

    // A classified command as it travels from the front end to the back end.
    typedef struct packed {
        op_t                  op;
        logic [CMD_IDX_W-1:0] idx_a;
        logic [CMD_IDX_W-1:0] idx_b;
        logic [CMD_IDX_W-1:0] idx_c;
        vertex_t              vtx;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_VTX_A,
        ST_VTX_B,
        ST_VTX_C,
        ST_MUL,
        ST_SUB,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_SUM_RD,
        ST_OUT
    } back_state_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mta_fifo.sv -----
// Small first-in first-out queue of packed items with queue-style handshakes.
// Depends on nothing; the item type is given by the instantiating module.
`default_nettype none

module mta_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  item_t     wdata,
    output logic      full,
    input  wire logic pop,
    output item_t     rdata,
    output logic      empty
);

    localparam int PTR_W = $clog2(DEPTH);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               wr_en;
    logic               rd_en;

    assign full  = (count_reg == (PTR_W + 1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push & ~full;
    assign rd_en = pop & ~empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mta_front.sv -----
// Front end: accepts input transactions, folds indices into the table and drops no-ops.
// Depends on mta_pkg for the item and command types.
`default_nettype none

module mta_front #(
    parameter int VERTEX_COUNT = 1024
) (
    input  mta_pkg::item_t item,
    input  wire logic      push,
    output logic           full,
    input  wire logic      cmd_full,
    input  wire logic      clearing,
    output mta_pkg::cmd_t  cmd,
    output logic           cmd_push
);

    // Repeated compare and subtract of shifted table sizes gives index mod VERTEX_COUNT.
    function automatic logic [mta_pkg::CMD_IDX_W-1:0] reduce_index(
        input logic [mta_pkg::IDX_W-1:0] idx
    );
        logic [23:0] v;
        logic [23:0] m;
        v = 24'(idx);
        for (int k = mta_pkg::REDUCE_STEPS - 1; k >= 0; k--)
        begin
            m = 24'(VERTEX_COUNT) << k;
            if (v >= m)
            begin
                v = v - m;
            end
        end
        return v[mta_pkg::CMD_IDX_W-1:0];
    endfunction

    mta_pkg::op_t op;

    assign op   = mta_pkg::op_t'(item.operation);
    assign full = cmd_full | clearing;

    always_comb
    begin
        cmd.op        = op;
        cmd.idx_a     = reduce_index(item.index_a);
        cmd.idx_b     = reduce_index(item.index_b);
        cmd.idx_c     = reduce_index(item.index_c);
        cmd.vtx.pos_x = item.pos_x;
        cmd.vtx.pos_y = item.pos_y;
        cmd.vtx.pos_z = item.pos_z;
        cmd.vtx.tex_u = item.tex_u;
        cmd.vtx.tex_v = item.tex_v;
    end

    // The unused operation code is accepted and has no effect.
    assign cmd_push = push & ~full & (op != mta_pkg::OP_NONE);

endmodule

`default_nettype wire

// ----- rtl/core/mta_divider.sv -----
// Bit-serial restoring divider: saturated (num * 2^16) / den, truncated toward zero.
// Depends on mta_pkg for widths and saturation limits.
`default_nettype none

module mta_divider (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [mta_pkg::NUM_W-1:0] num,
    input  wire logic signed [mta_pkg::DET_W-1:0] den,
    output logic                                done,
    output logic signed [mta_pkg::ACC_W-1:0]    quotient
);

    localparam int NUM_W = mta_pkg::NUM_W;
    localparam int DET_W = mta_pkg::DET_W;
    localparam int Q_W   = mta_pkg::ACC_W;
    localparam int LO_W  = Q_W - mta_pkg::FRAC_W;
    localparam int CNT_W = $clog2(Q_W);

    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] nmag;
    logic [DET_W-1:0] den_u;
    logic [DET_W-1:0] dmag;
    logic [DET_W-1:0] hi;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DET_W-1:0] rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   q_reg;
    logic [DET_W-1:0] dmag_reg;
    logic             sat_reg;
    logic             neg_reg;

    logic [DET_W:0]   rem_shift;
    logic             take;
    logic [DET_W:0]   rem_sub;
    logic             big;

    assign num_u = num;
    assign den_u = den;
    assign nmag  = num[NUM_W-1] ? (NUM_W'(0) - num_u) : num_u;
    assign dmag  = den[DET_W-1] ? (DET_W'(0) - den_u) : den_u;
    // Dividend bits above the quotient's 48 bits seed the remainder.
    assign hi    = DET_W'(nmag[NUM_W-1:LO_W]);

    assign rem_shift = {rem_reg, low_reg[Q_W-1]};
    assign take      = (rem_shift >= {1'b0, dmag_reg});
    assign rem_sub   = rem_shift - {1'b0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= hi;
            low_reg  <= {nmag[LO_W-1:0], mta_pkg::FRAC_W'(0)};
            q_reg    <= '0;
            dmag_reg <= dmag;
            sat_reg  <= (hi >= dmag);
            neg_reg  <= num[NUM_W-1] ^ den[DET_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? rem_sub[DET_W-1:0] : rem_shift[DET_W-1:0];
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], take};
        end
    end

    // A quotient of 2^47 or more saturates to the signed 48-bit range.
    assign big  = sat_reg | q_reg[Q_W-1];
    assign done = done_reg;

    always_comb
    begin
        if (big)
        begin
            quotient = neg_reg ? mta_pkg::ACC_MIN : mta_pkg::ACC_MAX;
        end
        else if (neg_reg)
        begin
            quotient = signed'(Q_W'(0) - q_reg);
        end
        else
        begin
            quotient = signed'(q_reg);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mta_back.sv -----
// Back end: vertex and accumulator memories, determinant and numerator sequencer,
// division and saturating accumulation. Depends on mta_pkg and mta_divider.
`default_nettype none

module mta_back #(
    parameter int VERTEX_COUNT = 1024
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [31:0] threshold,
    input  mta_pkg::cmd_t   cmd,
    input  wire logic       cmd_valid,
    output logic            cmd_pop,
    output mta_pkg::result_t res,
    output logic            res_push,
    input  wire logic       res_full,
    output logic            clearing
);

    localparam int AW     = $clog2(VERTEX_COUNT);
    localparam int PD_W   = mta_pkg::PD_W;
    localparam int TD_W   = mta_pkg::TD_W;
    localparam int PROD_W = mta_pkg::PROD_W;
    localparam int NUM_W  = mta_pkg::NUM_W;
    localparam int DET_W  = mta_pkg::DET_W;
    localparam int ACC_W  = mta_pkg::ACC_W;
    localparam int NNUM   = 6;
    localparam int NIDX_W = $clog2(NNUM);

    localparam logic [2:0] PAIR_LAST  = 3'd6;
    localparam logic [1:0] CORNER_C   = 2'd2;

    mta_pkg::back_state_t state_reg;
    mta_pkg::back_state_t state_next;

    mta_pkg::vertex_t vmem [VERTEX_COUNT];
    mta_pkg::vertex_t vq_reg;
    mta_pkg::sums_t   smem [VERTEX_COUNT];
    mta_pkg::sums_t   sq_reg;

    logic             vmem_we;
    logic [AW-1:0]    vmem_waddr;
    logic [AW-1:0]    vmem_raddr;
    logic             smem_we;
    logic [AW-1:0]    smem_waddr;
    logic [AW-1:0]    smem_raddr;
    mta_pkg::sums_t   smem_wdata;

    logic [AW-1:0]    clr_cnt_reg;
    logic [2:0]       pair_reg;
    logic             half_reg;
    logic [NIDX_W-1:0] div_idx_reg;
    logic [1:0]       corner_reg;

    mta_pkg::cmd_t    cmd_reg;
    mta_pkg::vertex_t a_reg;
    logic signed [PD_W-1:0]   p1_reg [3];
    logic signed [PD_W-1:0]   p2_reg [3];
    logic signed [TD_W-1:0]   u1_reg;
    logic signed [TD_W-1:0]   v1_reg;
    logic signed [TD_W-1:0]   u2_reg;
    logic signed [TD_W-1:0]   v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] first_reg;
    logic signed [DET_W-1:0]  det_reg;
    logic signed [NUM_W-1:0]  num_reg [NNUM];
    logic signed [ACC_W-1:0]  q_reg [NNUM];
    mta_pkg::result_t         res_reg;

    logic [AW-1:0]    addr_a;
    logic [AW-1:0]    addr_b;
    logic [AW-1:0]    addr_c;
    logic [AW-1:0]    corner_addr;
    logic [1:0]       dj;
    logic signed [PD_W-1:0]   mul_a;
    logic signed [TD_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [NUM_W-1:0]  diff;
    logic [DET_W-1:0] det_u;
    logic [DET_W-1:0] det_mag;
    logic             is_degenerate;
    logic             div_start;
    logic             div_done;
    logic signed [ACC_W-1:0]  div_q;

    assign addr_a = cmd_reg.idx_a[AW-1:0];
    assign addr_b = cmd_reg.idx_b[AW-1:0];
    assign addr_c = cmd_reg.idx_c[AW-1:0];

    always_comb
    begin
        unique case (corner_reg)
            2'd1:    corner_addr = addr_b;
            2'd2:    corner_addr = addr_c;
            default: corner_addr = addr_a;
        endcase
    end

    // One shared multiplier walks the determinant and the six numerators,
    // two products per term.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        dj    = 2'(pair_reg - 3'd1);
        unique case (pair_reg)
            3'd0:
            begin
                mul_a = half_reg ? PD_W'(v1_reg) : PD_W'(u1_reg);
                mul_b = half_reg ? u2_reg : v2_reg;
            end
            3'd1, 3'd2, 3'd3:
            begin
                mul_a = half_reg ? p2_reg[dj] : p1_reg[dj];
                mul_b = half_reg ? v1_reg : v2_reg;
            end
            3'd4, 3'd5, 3'd6:
            begin
                dj    = 2'(pair_reg - 3'd4);
                mul_a = half_reg ? p1_reg[dj] : p2_reg[dj];
                mul_b = half_reg ? u2_reg : u1_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign diff  = NUM_W'(first_reg) - NUM_W'(prod_reg);

    assign det_u         = det_reg;
    assign det_mag       = det_reg[DET_W-1] ? (DET_W'(0) - det_u) : det_u;
    assign is_degenerate = (det_mag <= DET_W'(threshold));

    always_comb
    begin
        smem_wdata.tx = mta_pkg::sat_add(sq_reg.tx, q_reg[0]);
        smem_wdata.ty = mta_pkg::sat_add(sq_reg.ty, q_reg[1]);
        smem_wdata.tz = mta_pkg::sat_add(sq_reg.tz, q_reg[2]);
        smem_wdata.bx = mta_pkg::sat_add(sq_reg.bx, q_reg[3]);
        smem_wdata.by = mta_pkg::sat_add(sq_reg.by, q_reg[4]);
        smem_wdata.bz = mta_pkg::sat_add(sq_reg.bz, q_reg[5]);
        if (state_reg == mta_pkg::ST_CLEAR)
        begin
            smem_wdata = '0;
        end
    end

    mta_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_reg[div_idx_reg]),
        .den      (det_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mta_pkg::ST_CLEAR:
                if (clr_cnt_reg == AW'(VERTEX_COUNT - 1))
                    state_next = mta_pkg::ST_IDLE;
            mta_pkg::ST_IDLE:
                if (cmd_valid)
                    state_next = mta_pkg::ST_DISPATCH;
            mta_pkg::ST_DISPATCH:
            begin
                unique case (cmd_reg.op)
                    mta_pkg::OP_TRIANGLE: state_next = mta_pkg::ST_VTX_A;
                    mta_pkg::OP_READ:     state_next = mta_pkg::ST_SUM_RD;
                    default:              state_next = mta_pkg::ST_IDLE;
                endcase
            end
            mta_pkg::ST_VTX_A: state_next = mta_pkg::ST_VTX_B;
            mta_pkg::ST_VTX_B: state_next = mta_pkg::ST_VTX_C;
            mta_pkg::ST_VTX_C: state_next = mta_pkg::ST_MUL;
            mta_pkg::ST_MUL:
                if (half_reg)
                    state_next = mta_pkg::ST_SUB;
            mta_pkg::ST_SUB:
            begin
                priority if (pair_reg == 3'd0)
                    state_next = mta_pkg::ST_CHECK;
                else if (pair_reg == PAIR_LAST)
                    state_next = mta_pkg::ST_DIV_START;
                else
                    state_next = mta_pkg::ST_MUL;
            end
            mta_pkg::ST_CHECK:
                state_next = is_degenerate ? mta_pkg::ST_OUT : mta_pkg::ST_MUL;
            mta_pkg::ST_DIV_START: state_next = mta_pkg::ST_DIV_WAIT;
            mta_pkg::ST_DIV_WAIT:
                if (div_done)
                    state_next = (div_idx_reg == NIDX_W'(NNUM - 1)) ?
                                 mta_pkg::ST_ACC_RD : mta_pkg::ST_DIV_START;
            mta_pkg::ST_ACC_RD: state_next = mta_pkg::ST_ACC_WR;
            mta_pkg::ST_ACC_WR:
                state_next = (corner_reg == CORNER_C) ? mta_pkg::ST_OUT : mta_pkg::ST_ACC_RD;
            mta_pkg::ST_SUM_RD: state_next = mta_pkg::ST_OUT;
            mta_pkg::ST_OUT:
                if (!res_full)
                    state_next = mta_pkg::ST_IDLE;
            default: state_next = mta_pkg::ST_IDLE;
        endcase
    end

    // Outputs and memory controls.
    always_comb
    begin
        cmd_pop    = (state_reg == mta_pkg::ST_IDLE) & cmd_valid;
        vmem_we    = (state_reg == mta_pkg::ST_DISPATCH) & (cmd_reg.op == mta_pkg::OP_WRITE);
        vmem_waddr = addr_a;
        unique case (state_reg)
            mta_pkg::ST_VTX_A: vmem_raddr = addr_b;
            mta_pkg::ST_VTX_B: vmem_raddr = addr_c;
            default:           vmem_raddr = addr_a;
        endcase
        smem_we    = (state_reg == mta_pkg::ST_CLEAR) | (state_reg == mta_pkg::ST_ACC_WR);
        smem_waddr = (state_reg == mta_pkg::ST_CLEAR) ? clr_cnt_reg : corner_addr;
        smem_raddr = (state_reg == mta_pkg::ST_ACC_RD) ? corner_addr : addr_a;
        div_start  = (state_reg == mta_pkg::ST_DIV_START);
        res_push   = (state_reg == mta_pkg::ST_OUT) & ~res_full;
        clearing   = (state_reg == mta_pkg::ST_CLEAR);
    end

    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            vmem[vmem_waddr] <= cmd_reg.vtx;
        end
        vq_reg <= vmem[vmem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            smem[smem_waddr] <= smem_wdata;
        end
        sq_reg <= smem[smem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mta_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            pair_reg    <= '0;
            half_reg    <= 1'b0;
            div_idx_reg <= '0;
            corner_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                mta_pkg::ST_CLEAR: clr_cnt_reg <= clr_cnt_reg + 1'b1;
                mta_pkg::ST_DISPATCH:
                begin
                    pair_reg    <= '0;
                    half_reg    <= 1'b0;
                    div_idx_reg <= '0;
                    corner_reg  <= '0;
                end
                mta_pkg::ST_MUL: half_reg <= ~half_reg;
                mta_pkg::ST_SUB:
                    if (pair_reg != PAIR_LAST)
                        pair_reg <= pair_reg + 1'b1;
                mta_pkg::ST_DIV_WAIT:
                    if (div_done)
                        div_idx_reg <= div_idx_reg + 1'b1;
                mta_pkg::ST_ACC_WR: corner_reg <= corner_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mta_pkg::ST_IDLE:
                if (cmd_valid)
                    cmd_reg <= cmd;
            mta_pkg::ST_VTX_A: a_reg <= vq_reg;
            mta_pkg::ST_VTX_B:
            begin
                p1_reg[0] <= PD_W'(vq_reg.pos_x) - PD_W'(a_reg.pos_x);
                p1_reg[1] <= PD_W'(vq_reg.pos_y) - PD_W'(a_reg.pos_y);
                p1_reg[2] <= PD_W'(vq_reg.pos_z) - PD_W'(a_reg.pos_z);
                u1_reg    <= TD_W'(vq_reg.tex_u) - TD_W'(a_reg.tex_u);
                v1_reg    <= TD_W'(vq_reg.tex_v) - TD_W'(a_reg.tex_v);
            end
            mta_pkg::ST_VTX_C:
            begin
                p2_reg[0] <= PD_W'(vq_reg.pos_x) - PD_W'(a_reg.pos_x);
                p2_reg[1] <= PD_W'(vq_reg.pos_y) - PD_W'(a_reg.pos_y);
                p2_reg[2] <= PD_W'(vq_reg.pos_z) - PD_W'(a_reg.pos_z);
                u2_reg    <= TD_W'(vq_reg.tex_u) - TD_W'(a_reg.tex_u);
                v2_reg    <= TD_W'(vq_reg.tex_v) - TD_W'(a_reg.tex_v);
            end
            mta_pkg::ST_MUL:
            begin
                prod_reg <= mul_p;
                if (half_reg)
                    first_reg <= prod_reg;
            end
            mta_pkg::ST_SUB:
            begin
                if (pair_reg == 3'd0)
                    det_reg <= DET_W'(diff);
                else
                    num_reg[NIDX_W'(pair_reg - 3'd1)] <= diff;
            end
            mta_pkg::ST_CHECK:
            begin
                res_reg             <= '0;
                res_reg.result_kind <= mta_pkg::KIND_STATUS;
                res_reg.degenerate  <= 1'b1;
            end
            mta_pkg::ST_DIV_WAIT:
                if (div_done)
                    q_reg[div_idx_reg] <= div_q;
            mta_pkg::ST_ACC_WR:
            begin
                res_reg             <= '0;
                res_reg.result_kind <= mta_pkg::KIND_STATUS;
            end
            mta_pkg::ST_SUM_RD:
            begin
                res_reg.result_kind <= mta_pkg::KIND_READ;
                res_reg.degenerate  <= 1'b0;
                res_reg.tangent_x   <= sq_reg.tx;
                res_reg.tangent_y   <= sq_reg.ty;
                res_reg.tangent_z   <= sq_reg.tz;
                res_reg.bitangent_x <= sq_reg.bx;
                res_reg.bitangent_y <= sq_reg.by;
                res_reg.bitangent_z <= sq_reg.bz;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/mesh_tangent_accumulator.sv -----
// Top level of the mesh tangent accumulator: configuration register, queues, front and back.
// Depends on mta_pkg, mta_fifo, mta_front and mta_back.
//
//   Channel   Handshake            Payload        Transaction when
//   item      push / full          mta_pkg::item_t   push && !full
//   result    pop / empty          mta_pkg::result_t pop && !empty
//   config    psel penable pwrite  pwdata, paddr    psel && penable && pwrite && pready
//
// A triangle uses the shared multiplier for the determinant and, unless its magnitude is at
// or below the threshold (a degenerate status), for six numerators, then gets six quotients
// from the bit-serial divider, then does three read-modify-write accumulations. After reset
// the accumulator memory is cleared one entry per cycle, every entry in turn, while full
// stays high. A stalled result queue holds the back end in its output state; up to two
// classified commands wait in the queue between the two halves.
`default_nettype none

module mesh_tangent_accumulator #(
    parameter int VERTEX_COUNT = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  mta_pkg::item_t   item,
    output logic             empty,
    input  wire logic        pop,
    output mta_pkg::result_t result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0]      threshold_reg;
    logic             cfg_write;

    mta_pkg::cmd_t    front_cmd;
    logic             front_push;
    logic             cmd_full;
    mta_pkg::cmd_t    back_cmd;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             clearing;

    mta_pkg::result_t back_res;
    logic             res_push;
    logic             res_full;

    // The threshold register sits at byte address zero; bit 2 selects the register.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & ~paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= mta_pkg::THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            threshold_reg <= pwdata;
        end
    end

    // Front end classifies each transaction and folds its indices into the table.
    mta_front #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_front (
        .item     (item),
        .push     (push),
        .full     (full),
        .cmd_full (cmd_full),
        .clearing (clearing),
        .cmd      (front_cmd),
        .cmd_push (front_push)
    );

    // Command queue decouples the input side from the long triangle sequence.
    mta_fifo #(
        .item_t (mta_pkg::cmd_t),
        .DEPTH  (2)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    // Back end owns the memories, the multiplier, the divider and the accumulators.
    mta_back #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .cmd       (back_cmd),
        .cmd_valid (~cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (back_res),
        .res_push  (res_push),
        .res_full  (res_full),
        .clearing  (clearing)
    );

    // Result queue lets the back end finish while the consumer stalls.
    mta_fifo #(
        .item_t (mta_pkg::result_t),
        .DEPTH  (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire
